### rtl/core/rpa_pkg.sv
package rpa_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W = 34;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned SHOW_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Parameter defaults for the top level
  localparam int unsigned NUM_PAGES_DEF   = 32768;
  localparam int unsigned PAGE_SHIFT_DEF  = 12;
  localparam int unsigned COUNT_WIDTH_DEF = 8;
  localparam int unsigned QUEUE_DEPTH     = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
  localparam logic [OP_W-1:0] OP_ADDREF = 3'd2;
  localparam logic [OP_W-1:0] OP_DECREF = 3'd3;
  localparam logic [OP_W-1:0] OP_SEED   = 3'd4;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [STAT_W-1:0] ST_BADADDR   = 3'd2;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd3;
  localparam logic [STAT_W-1:0] ST_CORRUPT   = 3'd4;
  localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd5;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd6;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_BOUND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_BOUND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BASE = 2'd2;

  localparam logic [ADDR_W-1:0] LOW_BOUND_RST  = 34'h080000000;
  localparam logic [ADDR_W-1:0] HIGH_BOUND_RST = 34'h088000000;
  localparam logic [ADDR_W-1:0] COUNT_BASE_RST = 34'h080000000;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] page_address;
    logic [SHOW_W-1:0] count;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0] low_bound;
    logic [ADDR_W-1:0] high_bound;
    logic [ADDR_W-1:0] count_base;
  } cfg_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] offset;   // address - count_base
    logic              ge_base;  // address >= count_base
    logic              addr_ok;  // aligned, in bounds, at or above base
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

### rtl/core/rpa_fifo.sv
module rpa_fifo #(
  parameter int unsigned DEPTH = rpa_pkg::QUEUE_DEPTH,
  parameter int unsigned WIDTH = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign full_o  = (cnt_q == FULL_CNT);
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### rtl/core/rpa_front.sv
module rpa_front #(
  parameter int unsigned PAGE_SHIFT = rpa_pkg::PAGE_SHIFT_DEF
) (
  input  rpa_pkg::req_t req_i,
  input  rpa_pkg::cfg_t cfg_i,
  output rpa_pkg::cmd_t cmd_o
);

  logic [rpa_pkg::ADDR_W:0] diff;
  logic                     aligned, in_bounds;

  // Offset from the count base, borrow tells below-base addresses
  assign diff      = {1'b0, req_i.address} - {1'b0, cfg_i.count_base};
  assign aligned   = (req_i.address[PAGE_SHIFT-1:0] == '0);
  assign in_bounds = (req_i.address >= cfg_i.low_bound) &&
                     (req_i.address < cfg_i.high_bound);

  // Classify the request for the back end
  always_comb begin
    cmd_o.op      = req_i.op;
    cmd_o.offset  = diff[rpa_pkg::ADDR_W-1:0];
    cmd_o.ge_base = !diff[rpa_pkg::ADDR_W];
    cmd_o.addr_ok = aligned && in_bounds && !diff[rpa_pkg::ADDR_W];
  end

endmodule

### rtl/core/rpa_back.sv
module rpa_back #(
  parameter int unsigned NUM_PAGES   = rpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rpa_pkg::cmd_t               cmd_i,
  input  logic                        cmd_empty_i,
  output logic                        cmd_pop_o,
  input  logic [rpa_pkg::ADDR_W-1:0]  count_base_i,
  output rpa_pkg::rsp_t               rsp_o,
  output logic                        rsp_push_o,
  input  logic                        rsp_full_i,
  output rpa_pkg::back_stat_t         stat_o
);

  localparam int unsigned IDX_W  = $clog2(NUM_PAGES);
  localparam int unsigned LINK_W = $clog2(NUM_PAGES + 1);
  localparam int unsigned CW     = COUNT_WIDTH;

  localparam logic [rpa_pkg::ADDR_W-1:0] NUM_A = rpa_pkg::ADDR_W'(NUM_PAGES);
  localparam logic [LINK_W-1:0] NUM_L    = LINK_W'(NUM_PAGES);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_PAGES - 1);
  localparam logic [CW-1:0]     CNT_ONE  = CW'(1);
  localparam logic [CW-1:0]     CNT_MAX  = '1;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [IDX_W-1:0]    clr_q, clr_d;
  logic [IDX_W-1:0]    head_q, head_d;
  logic                hv_q, hv_d;

  logic [rpa_pkg::OP_W-1:0] op_q;
  logic [IDX_W-1:0]    idx_q;
  logic                idx_ok_q, free_ok_q;

  logic [CW-1:0]       ref_mem [NUM_PAGES];
  logic [LINK_W-1:0]   link_mem [NUM_PAGES];
  logic [CW-1:0]       cnt_rd_q;
  logic [LINK_W-1:0]   link_rd_q;

  logic [rpa_pkg::ADDR_W-1:0] page_off;
  logic [IDX_W-1:0]    cmd_idx, rd_idx;
  logic                cmd_idx_ok;

  logic                ref_we, ref_set_we, link_we, list_push;
  logic [IDX_W-1:0]    ref_waddr;
  logic [CW-1:0]       ref_wdata, ref_set_val;
  logic [LINK_W-1:0]   link_wdata;

  logic [CW-1:0]       show_src;
  logic                show_en;
  logic [rpa_pkg::SHOW_W-1:0] shown;

  logic [rpa_pkg::STAT_W-1:0] rsp_status;
  logic [rpa_pkg::ADDR_W-1:0] rsp_page;
  logic [rpa_pkg::SHOW_W-1:0] rsp_count;

  // Decode the page index of the waiting command
  assign page_off   = cmd_i.offset >> PAGE_SHIFT;
  assign cmd_idx    = IDX_W'(page_off);
  assign cmd_idx_ok = cmd_i.ge_base && (page_off < NUM_A);
  assign rd_idx     = (cmd_i.op == rpa_pkg::OP_ALLOC) ? head_q : cmd_idx;

  assign cmd_pop_o = (state_q == S_READ) && !cmd_empty_i && !rsp_full_i;

  // Sequence: clear pass, then read and execute per command
  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == LAST_IDX) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (cmd_pop_o) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_READ;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  // Carry out the command against the read count and link
  always_comb begin
    rsp_status  = rpa_pkg::ST_IGNORED;
    rsp_page    = '0;
    show_src    = '0;
    show_en     = 1'b0;
    ref_set_we  = 1'b0;
    ref_set_val = '0;
    list_push   = 1'b0;
    head_d      = head_q;
    hv_d        = hv_q;
    unique case (op_q)
      rpa_pkg::OP_ALLOC: begin
        if (!hv_q) begin
          rsp_status = rpa_pkg::ST_EMPTY;
        end else begin
          if (link_rd_q != '0 && link_rd_q <= NUM_L) begin
            head_d = IDX_W'(link_rd_q - LINK_W'(1));
            hv_d   = 1'b1;
          end else begin
            head_d = '0;
            hv_d   = 1'b0;
          end
          if (cnt_rd_q != '0) begin
            rsp_status = rpa_pkg::ST_CORRUPT;
            show_src   = cnt_rd_q;
            show_en    = 1'b1;
          end else begin
            rsp_status  = rpa_pkg::ST_OK;
            rsp_page    = count_base_i + (rpa_pkg::ADDR_W'(idx_q) << PAGE_SHIFT);
            ref_set_we  = 1'b1;
            ref_set_val = CNT_ONE;
            show_src    = CNT_ONE;
            show_en     = 1'b1;
          end
        end
      end
      rpa_pkg::OP_FREE: begin
        if (!free_ok_q) begin
          rsp_status = rpa_pkg::ST_BADADDR;
        end else if (cnt_rd_q == '0) begin
          rsp_status = rpa_pkg::ST_UNDERFLOW;
        end else begin
          rsp_status  = rpa_pkg::ST_OK;
          ref_set_we  = 1'b1;
          ref_set_val = cnt_rd_q - CNT_ONE;
          list_push   = (cnt_rd_q == CNT_ONE);
          show_src    = cnt_rd_q - CNT_ONE;
          show_en     = 1'b1;
        end
      end
      rpa_pkg::OP_ADDREF: begin
        if (idx_ok_q) begin
          show_en = 1'b1;
          if (cnt_rd_q == CNT_MAX) begin
            rsp_status = rpa_pkg::ST_OVERFLOW;
            show_src   = CNT_MAX;
          end else begin
            rsp_status  = rpa_pkg::ST_OK;
            ref_set_we  = 1'b1;
            ref_set_val = cnt_rd_q + CNT_ONE;
            show_src    = cnt_rd_q + CNT_ONE;
          end
        end
      end
      rpa_pkg::OP_DECREF: begin
        if (idx_ok_q) begin
          if (cnt_rd_q == '0) begin
            rsp_status = rpa_pkg::ST_UNDERFLOW;
          end else if (cnt_rd_q == CNT_ONE) begin
            if (!free_ok_q) begin
              rsp_status = rpa_pkg::ST_BADADDR;
              show_src   = CNT_ONE;
              show_en    = 1'b1;
            end else begin
              // last reference: drop to zero and push exactly once
              rsp_status  = rpa_pkg::ST_OK;
              ref_set_we  = 1'b1;
              ref_set_val = '0;
              list_push   = 1'b1;
            end
          end else begin
            rsp_status  = rpa_pkg::ST_OK;
            ref_set_we  = 1'b1;
            ref_set_val = cnt_rd_q - CNT_ONE;
            show_src    = cnt_rd_q - CNT_ONE;
            show_en     = 1'b1;
          end
        end
      end
      rpa_pkg::OP_SEED: begin
        if (!free_ok_q) begin
          rsp_status = rpa_pkg::ST_BADADDR;
        end else begin
          rsp_status  = rpa_pkg::ST_OK;
          ref_set_we  = 1'b1;
          ref_set_val = '0;
          list_push   = 1'b1;
        end
      end
      default: begin
        rsp_status = rpa_pkg::ST_IGNORED;
      end
    endcase
    if (list_push) begin
      head_d = idx_q;
      hv_d   = 1'b1;
    end
  end

  // Saturate or zero-extend the shown count to the result width
  if (CW > rpa_pkg::SHOW_W) begin : g_sat
    assign shown = (|show_src[CW-1:rpa_pkg::SHOW_W]) ? '1 : show_src[rpa_pkg::SHOW_W-1:0];
  end else begin : g_ext
    assign shown = rpa_pkg::SHOW_W'(show_src);
  end
  assign rsp_count = show_en ? shown : '0;
  assign rsp_o     = {rsp_status, rsp_page, rsp_count};

  assign rsp_push_o = (state_q == S_EXEC);

  // Memory write ports: clear pass or execute stage
  assign ref_we     = (state_q == S_CLEAR) || (rsp_push_o && ref_set_we);
  assign ref_waddr  = (state_q == S_CLEAR) ? clr_q : idx_q;
  assign ref_wdata  = (state_q == S_CLEAR) ? '0 : ref_set_val;
  assign link_we    = rsp_push_o && list_push;
  assign link_wdata = hv_q ? LINK_W'(head_q) + LINK_W'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (ref_we) begin
      ref_mem[ref_waddr] <= ref_wdata;
    end
    if (cmd_pop_o) begin
      cnt_rd_q <= ref_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[idx_q] <= link_wdata;
    end
    if (cmd_pop_o) begin
      link_rd_q <= link_mem[rd_idx];
    end
  end

  // Latch the command taken from the queue
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      op_q      <= cmd_i.op;
      idx_q     <= rd_idx;
      idx_ok_q  <= cmd_idx_ok;
      free_ok_q <= cmd_i.addr_ok && cmd_idx_ok;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      head_q  <= '0;
      hv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (rsp_push_o) begin
        head_q <= head_d;
        hv_q   <= hv_d;
      end
    end
  end

  assign stat_o.clearing = (state_q == S_CLEAR);

  // No command is taken while the count store is being cleared
  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !cmd_pop_o)
    else $error("command taken during clear pass");

  // Every command taken yields exactly one result on the next cycle
  a_pop_then_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |=> (rsp_push_o && !cmd_pop_o))
    else $error("command not executed in the cycle after read");

  // A result never lands in a full output queue
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push_o |-> !rsp_full_i)
    else $error("result pushed into full queue");

  // A list push leaves the list non-empty with the pushed page at the head
  a_push_sets_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_we) |=> (hv_q && head_q == $past(idx_q)))
    else $error("list push did not update head");

endmodule

### rtl/core/refcounted_page_allocator_unit.sv
// Reference-counted page allocator.
// Requests enter as a queue: drive req_i and raise push; a request is taken at
// a rising edge with push high and full low. Results leave as a queue: while
// empty is low the oldest result is on rsp_o, and pop high at an edge takes it.
// Every request gives exactly one result, in request order.
// Configuration: cfg_index_i selects low_bound (0), high_bound (1) or
// count_base (2); a write completes when cfg_valid_i and cfg_ready_o are high.
// Write only while no request is pending.
// The execute sequencer takes a new request only after executing the last one:
// it reads the count and link memories when it takes a request and writes them
// in the next cycle. Reset: the free list is empty and the count memory is
// swept to zero, one entry a cycle, over all NUM_PAGES entries; full stays
// high during the sweep. When the consumer stops popping, the result queue
// fills, the sequencer halts, the request queue fills and full goes high;
// nothing is dropped.
module refcounted_page_allocator_unit #(
  parameter int unsigned NUM_PAGES   = rpa_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT  = rpa_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned COUNT_WIDTH = rpa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  rpa_pkg::req_t                 req_i,
  output logic                          empty,
  input  logic                          pop,
  output rpa_pkg::rsp_t                 rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rpa_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rpa_pkg::ADDR_W-1:0]    cfg_data_i
);

  localparam int unsigned CMD_W = $bits(rpa_pkg::cmd_t);
  localparam int unsigned RSP_W = $bits(rpa_pkg::rsp_t);

  rpa_pkg::cfg_t       cfg_q;
  rpa_pkg::cmd_t       cmd_in, cmd_out;
  rpa_pkg::rsp_t       rsp_in;
  rpa_pkg::back_stat_t back_stat;
  logic                cmd_full, cmd_empty, cmd_pop, cmd_push;
  logic                rsp_push, rsp_full;

  // Hold configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_bound  <= rpa_pkg::LOW_BOUND_RST;
      cfg_q.high_bound <= rpa_pkg::HIGH_BOUND_RST;
      cfg_q.count_base <= rpa_pkg::COUNT_BASE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rpa_pkg::CFG_LOW_BOUND:  cfg_q.low_bound  <= cfg_data_i;
        rpa_pkg::CFG_HIGH_BOUND: cfg_q.high_bound <= cfg_data_i;
        rpa_pkg::CFG_COUNT_BASE: cfg_q.count_base <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stall requests while the queue is full or the count store is clearing
  assign full     = cmd_full || back_stat.clearing;
  assign cmd_push = push && !full;

  rpa_front #(
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .req_i (req_i),
    .cfg_i (cfg_q),
    .cmd_o (cmd_in)
  );

  rpa_fifo #(
    .DEPTH (rpa_pkg::QUEUE_DEPTH),
    .WIDTH (CMD_W)
  ) u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out),
    .empty_o (cmd_empty)
  );

  rpa_back #(
    .NUM_PAGES   (NUM_PAGES),
    .PAGE_SHIFT  (PAGE_SHIFT),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_out),
    .cmd_empty_i  (cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .count_base_i (cfg_q.count_base),
    .rsp_o        (rsp_in),
    .rsp_push_o   (rsp_push),
    .rsp_full_i   (rsp_full),
    .stat_o       (back_stat)
  );

  rpa_fifo #(
    .DEPTH (rpa_pkg::QUEUE_DEPTH),
    .WIDTH (RSP_W)
  ) u_rsp_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (rsp_in),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .data_o  (rsp_o),
    .empty_o (empty)
  );

endmodule

### tb/page_alloc_checker.sv
module page_alloc_checker
  import rpa_pkg::*;
#(
  parameter int unsigned NUM_PAGES   = NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT  = PAGE_SHIFT_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  input  logic                 full,
  input  req_t                 req_i,
  input  logic                 empty,
  input  logic                 pop,
  input  rsp_t                 rsp_o,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ADDR_W-1:0]    cfg_data_i,
  output int unsigned          errors_o,
  output int unsigned          outstanding_o,
  output int unsigned          checked_o,
  output logic [7:0]           statuses_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Shadow copy of the allocator: address map, free list and count store
  logic [ADDR_W-1:0]      lo_lim   = LOW_BOUND_RST;
  logic [ADDR_W-1:0]      hi_lim   = HIGH_BOUND_RST;
  logic [ADDR_W-1:0]      idx_base = COUNT_BASE_RST;
  int unsigned            head_page;
  bit                     head_valid;
  int unsigned            link_mem  [NUM_PAGES];
  logic [COUNT_WIDTH-1:0] count_mem [NUM_PAGES];

  rsp_t        due_results [$];
  int unsigned errors;
  int unsigned checked;
  logic [7:0]  seen;

  // Map an address to its page slot; false when it lies outside the count store
  function automatic bit page_slot(input logic [ADDR_W-1:0] a, output int unsigned idx);
    logic [ADDR_W-1:0] d;
    idx = 0;
    if (a < idx_base) return 1'b0;
    d = (a - idx_base) >> PAGE_SHIFT;
    if (d >= NUM_PAGES) return 1'b0;
    idx = int'(d);
    return 1'b1;
  endfunction

  // Aligned, inside the bounds, and backed by a count entry
  function automatic bit releasable(input logic [ADDR_W-1:0] a, output int unsigned idx);
    idx = 0;
    if (a[PAGE_SHIFT-1:0] != '0) return 1'b0;
    if (a < lo_lim || a >= hi_lim) return 1'b0;
    return page_slot(a, idx);
  endfunction

  function automatic void push_page(input int unsigned idx);
    link_mem[idx] = head_valid ? head_page + 1 : 0;
    head_page     = idx;
    head_valid    = 1'b1;
  endfunction

  function automatic logic [SHOW_W-1:0] shown(input logic [COUNT_WIDTH-1:0] c);
    return (c > 255) ? {SHOW_W{1'b1}} : SHOW_W'(c);
  endfunction

  // Apply one request to the shadow state and return the response it must give
  function automatic rsp_t apply_request(input req_t r);
    rsp_t        res;
    int unsigned idx;
    int unsigned chk;
    int unsigned nxt;
    res.status       = ST_IGNORED;
    res.page_address = '0;
    res.count        = '0;
    case (r.op)
      OP_ALLOC: begin
        if (!head_valid) begin
          res.status = ST_EMPTY;
        end else begin
          idx = head_page;
          nxt = link_mem[idx];
          if (nxt != 0 && nxt <= NUM_PAGES) begin
            head_page  = nxt - 1;
            head_valid = 1'b1;
          end else begin
            head_page  = 0;
            head_valid = 1'b0;
          end
          // A listed page that still holds references is dropped
          if (count_mem[idx] != '0) begin
            res.status = ST_CORRUPT;
            res.count  = shown(count_mem[idx]);
          end else begin
            count_mem[idx]   = COUNT_WIDTH'(1);
            res.status       = ST_OK;
            res.page_address = idx_base + (ADDR_W'(idx) << PAGE_SHIFT);
            res.count        = SHOW_W'(1);
          end
        end
      end
      OP_FREE: begin
        if (!releasable(r.address, idx)) begin
          res.status = ST_BADADDR;
        end else if (count_mem[idx] == '0) begin
          res.status = ST_UNDERFLOW;
        end else begin
          count_mem[idx] = count_mem[idx] - 1'b1;
          if (count_mem[idx] == '0) push_page(idx);
          res.status = ST_OK;
          res.count  = shown(count_mem[idx]);
        end
      end
      OP_ADDREF: begin
        if (page_slot(r.address, idx)) begin
          if (count_mem[idx] == COUNT_MAX) begin
            res.status = ST_OVERFLOW;
          end else begin
            count_mem[idx] = count_mem[idx] + 1'b1;
            res.status     = ST_OK;
          end
          res.count = shown(count_mem[idx]);
        end
      end
      OP_DECREF: begin
        if (page_slot(r.address, idx)) begin
          if (count_mem[idx] == '0) begin
            res.status = ST_UNDERFLOW;
          end else if (count_mem[idx] == COUNT_WIDTH'(1) && !releasable(r.address, chk)) begin
            // Last reference on an address that could not be freed: keep it
            res.status = ST_BADADDR;
            res.count  = SHOW_W'(1);
          end else begin
            // Last reference releases the page exactly once
            count_mem[idx] = count_mem[idx] - 1'b1;
            if (count_mem[idx] == '0) push_page(idx);
            res.status = ST_OK;
            res.count  = shown(count_mem[idx]);
          end
        end
      end
      OP_SEED: begin
        if (!releasable(r.address, idx)) begin
          res.status = ST_BADADDR;
        end else begin
          count_mem[idx] = '0;
          push_page(idx);
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Track register writes, check each popped response, predict each pushed request
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    rsp_t want;
    int   i;
    if (!rst_ni) begin
      lo_lim     = LOW_BOUND_RST;
      hi_lim     = HIGH_BOUND_RST;
      idx_base   = COUNT_BASE_RST;
      head_page  = 0;
      head_valid = 1'b0;
      for (i = 0; i < NUM_PAGES; i++) count_mem[i] = '0;
      due_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LOW_BOUND:  lo_lim   = cfg_data_i;
          CFG_HIGH_BOUND: hi_lim   = cfg_data_i;
          CFG_COUNT_BASE: idx_base = cfg_data_i;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected response: status %0d page %h count %0d", $time,
                   rsp_o.status, rsp_o.page_address, rsp_o.count);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (rsp_o.status !== want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d", $time,
                     want.status, rsp_o.status);
            errors++;
          end
          if (rsp_o.page_address !== want.page_address) begin
            $display("%0t: page address mismatch: expected %h, got %h", $time,
                     want.page_address, rsp_o.page_address);
            errors++;
          end
          if (rsp_o.count !== want.count) begin
            $display("%0t: count mismatch: expected %0d, got %0d", $time,
                     want.count, rsp_o.count);
            errors++;
          end
          seen[want.status] = 1'b1;
          checked++;
        end
      end
      if (push && !full) due_results.push_back(apply_request(req_i));
    end
    errors_o      <= errors;
    outstanding_o <= due_results.size();
    checked_o     <= checked;
    statuses_o    <= seen;
  end

  initial begin
    errors  = 0;
    checked = 0;
    seen    = '0;
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpa_pkg::*;

  localparam int unsigned       NUM_PAGES   = NUM_PAGES_DEF;
  localparam logic [ADDR_W-1:0] PAGE_BYTES  = ADDR_W'(1) << PAGE_SHIFT_DEF;
  localparam logic [ADDR_W-1:0] PAGE_MASK   = PAGE_BYTES - 1'b1;
  localparam logic [ADDR_W-1:0] ADDR_ONES   = '1;
  localparam logic [OP_W-1:0]   OP_UNDEF_LO = 3'd5;
  localparam logic [OP_W-1:0]   OP_UNDEF_HI = 3'd7;
  localparam int unsigned       POOL        = 24;  // pages the random traffic works on
  localparam int unsigned       POOL_LOW    = 20;  // of them at the bottom of the map
  localparam int unsigned       LONG_HOLD   = 150;
  localparam int unsigned       SETTLE      = 10;
  localparam int unsigned       TIMEOUT_NS  = 5_000_000;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 push        = 1'b0;
  logic                 pop         = 1'b0;
  logic                 cfg_valid_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [ADDR_W-1:0]    cfg_data_i  = '0;
  req_t                 req_i       = '0;
  logic                 full;
  logic                 empty;
  logic                 cfg_ready_o;
  rsp_t                 rsp_o;

  int unsigned errors;
  int unsigned outstanding;
  int unsigned checked;
  logic [7:0]  seen_status;

  // Traffic shaping: calm is shared by both sides, long_hold holds off the response side
  bit calm      = 1'b0;
  bit long_hold = 1'b0;

  // Address map as last programmed, used to aim the requests
  logic [ADDR_W-1:0] cur_base = COUNT_BASE_RST;
  int unsigned       n_sent   = 0;
  int unsigned       n_maps   = 1;

  refcounted_page_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  page_alloc_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .req_i         (req_i),
    .empty         (empty),
    .pop           (pop),
    .rsp_o         (rsp_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .errors_o      (errors),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .statuses_o    (seen_status)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Regression FAIL");
    $finish;
  end

  // Pool page k: the first POOL_LOW pages from the count base, and the last four slots of the count store
  function automatic logic [ADDR_W-1:0] pool_page(input int unsigned k);
    logic [ADDR_W-1:0] first;
    first = (cur_base + PAGE_MASK) & ~PAGE_MASK;
    if (k < POOL_LOW) return first + ADDR_W'(k) * PAGE_BYTES;
    return first + ADDR_W'(NUM_PAGES - POOL + k) * PAGE_BYTES;
  endfunction

  function automatic logic [ADDR_W-1:0] random_target();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return pool_page($urandom_range(0, POOL - 1));
    if (r < 85) return pool_page($urandom_range(0, POOL - 1)) + ($urandom & PAGE_MASK | 1'b1);
    if (r < 89) return pool_page(0) - PAGE_BYTES;
    if (r < 92) return pool_page(POOL - 1) + PAGE_BYTES;
    if (r < 98) return ADDR_W'({$urandom, $urandom});
    return (r == 98) ? '0 : ADDR_ONES;
  endfunction

  function automatic logic [OP_W-1:0] random_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return OP_ALLOC;
    if (r < 48) return OP_FREE;
    if (r < 66) return OP_ADDREF;
    if (r < 84) return OP_DECREF;
    if (r < 96) return OP_SEED;
    return OP_W'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
  endfunction

  // Offer one request after a random idle gap, none when calm; return once the transaction is taken
  task automatic send_req(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] address);
    req_t        r;
    int unsigned gap;
    r.op      = op;
    r.address = address;
    gap = calm ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (full);
    n_sent++;
  endtask

  // Stop offering and wait until every predicted response has been popped
  task automatic wait_drained();
    push <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all three address map registers back to back
  task automatic program_map(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
                             input logic [ADDR_W-1:0] base);
    logic [CFG_IDX_W-1:0] idx  [3];
    logic [ADDR_W-1:0]    vals [3];
    int                   i;
    idx  = '{CFG_LOW_BOUND, CFG_HIGH_BOUND, CFG_COUNT_BASE};
    vals = '{lo, hi, base};
    cfg_valid_i <= 1'b1;
    for (i = 0; i < 3; i++) begin
      cfg_index_i <= idx[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cur_base = base;
    n_maps++;
  endtask

  task automatic seed_pool(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) send_req(OP_SEED, pool_page(k % POOL));
  endtask

  task automatic run_mix(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (i % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      send_req(random_op(), random_target());
    end
    calm = 1'b0;
  endtask

  // Response side: pop after a random gap, none when calm, or hold off for a long stretch on request
  initial begin : result_sink
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        gap       = LONG_HOLD;
        long_hold = 1'b0;
      end else if (calm) begin
        gap = 0;
      end else begin
        gap = $urandom_range(0, 8);
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] base0;
    logic [ADDR_W-1:0] last_page;
    logic [ADDR_W-1:0] hammer;
    int unsigned       i;
    base0     = COUNT_BASE_RST;
    last_page = HIGH_BOUND_RST - PAGE_BYTES;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners under the reset address map
    send_req(OP_ALLOC, '0);                       // empty list
    send_req(OP_SEED, base0);
    send_req(OP_SEED, base0 + PAGE_BYTES);
    send_req(OP_SEED, base0 + 34'h10);            // misaligned
    send_req(OP_SEED, base0 - PAGE_BYTES);        // below the low bound
    send_req(OP_SEED, HIGH_BOUND_RST);            // at the high bound
    send_req(OP_SEED, last_page);
    send_req(OP_ALLOC, ADDR_ONES);
    send_req(OP_ADDREF, last_page);
    send_req(OP_DECREF, last_page);
    send_req(OP_DECREF, last_page);               // last reference goes back on the list
    send_req(OP_DECREF, last_page);               // already zero
    send_req(OP_ADDREF, base0);                   // reference on a page still listed
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);
    send_req(OP_ALLOC, '0);                       // listed page with references
    send_req(OP_ALLOC, '0);
    send_req(OP_FREE, base0 + PAGE_BYTES);
    send_req(OP_FREE, base0 + PAGE_BYTES);        // free of a zero count
    send_req(OP_DECREF, base0 + 34'h123);         // last reference, address not freeable
    send_req(OP_ADDREF, base0 - PAGE_BYTES);      // outside the count store
    send_req(OP_DECREF, HIGH_BOUND_RST);          // one past the last slot
    send_req(OP_UNDEF_LO, ADDR_ONES);
    send_req(OP_UNDEF_HI, '0);
    send_req(OP_FREE, ADDR_ONES);
    send_req(OP_FREE, base0);
    send_req(OP_ALLOC, '0);

    // Reset map: fill the list, then back-pressure with the consumer held off
    seed_pool(16);
    long_hold = 1'b1;
    calm      = 1'b1;
    for (i = 0; i < 40; i++) send_req(random_op(), random_target());
    calm = 1'b0;
    run_mix(120);

    // Drive one page's count into saturation and back down
    hammer = pool_page(5);
    calm   = 1'b1;
    repeat (258) send_req(OP_ADDREF, hammer);
    calm = 1'b0;
    repeat (3) send_req(OP_DECREF, hammer);
    send_req(OP_FREE, hammer);
    wait_drained();

    // Whole address space usable, count store at address zero
    program_map('0, ADDR_ONES, '0);
    seed_pool(16);
    run_mix(70);
    wait_drained();
    run_mix(70);
    wait_drained();

    // Empty bounds window, count store at the top of the address space
    program_map(ADDR_ONES, '0, ADDR_ONES & ~PAGE_MASK);
    seed_pool(4);
    run_mix(60);
    wait_drained();

    // Misaligned count base with a narrow bounds window
    program_map(34'h012346000, 34'h012360000, 34'h012345678);
    seed_pool(16);
    run_mix(180);
    wait_drained();

    // Back to the reset map; the list still holds pages from the earlier maps
    program_map(LOW_BOUND_RST, HIGH_BOUND_RST, COUNT_BASE_RST);
    seed_pool(8);
    run_mix(150);
    wait_drained();

    $display("Sent %0d requests under %0d address maps; %0d responses checked",
             n_sent, n_maps, checked);
    $display("Response statuses seen, one bit per code: %b", seen_status[6:0]);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/rpa_pkg.sv
rtl/core/rpa_fifo.sv
rtl/core/rpa_front.sv
rtl/core/rpa_back.sv
rtl/core/refcounted_page_allocator_unit.sv
tb/page_alloc_checker.sv
tb/tb.sv
